/* src/gfsr_pkg.sv */
// Shared types, sizes and codes of the lagged XOR word generator.
`default_nettype none

package gfsr_pkg;

	// Table geometry and feedback tap.
	localparam int TABLE_WORDS = 98;
	localparam int TAP_OFFSET  = 27;
	localparam int TAP_MOD     = TAP_OFFSET % TABLE_WORDS;
	localparam int PTR_W       = $clog2(TABLE_WORDS);

	// Field widths of the request and response items.
	localparam int WORD_W  = 32;
	localparam int IDX_W   = 7;
	localparam int RANGE_W = 31;

	// Iteration counter of the remainder unit.
	localparam int DIV_CNT_W = $clog2(WORD_W + 1);

	// Request kinds.
	typedef enum logic [1:0] {
		KIND_LOAD_WORD  = 2'd0,
		KIND_LOAD_PTR   = 2'd1,
		KIND_DRAW_RAW   = 2'd2,
		KIND_DRAW_RANGE = 2'd3
	} req_kind_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_XOR,
		ST_DIV,
		ST_FINISH
	} state_t;

	// One request item.
	typedef struct packed {
		logic [1:0]         req_type;
		logic [IDX_W-1:0]   word_index;
		logic [WORD_W-1:0]  seed_value;
		logic [RANGE_W-1:0] range_low;
		logic [RANGE_W-1:0] range_high;
	} req_t;

	// One response item.
	typedef struct packed {
		logic [WORD_W-1:0] draw_value;
		logic              status;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic mem_load;
		logic ptr_load;
		logic advance;
		logic commit;
		logic div_start;
		logic rsp_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		req_kind_t kind;
		logic      range_err;
		logic      div_done;
	} sts_t;

endpackage

`default_nettype wire

/* src/gfsr_div.sv */
// Radix-2 restoring remainder unit, one quotient bit per cycle.
`default_nettype none

module gfsr_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [gfsr_pkg::WORD_W-1:0]   dividend,
	input  wire logic [gfsr_pkg::WORD_W-1:0]   divisor,
	output logic                               done,
	output logic [gfsr_pkg::WORD_W-1:0]        remainder
);

	logic [gfsr_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           done_q;
	logic [gfsr_pkg::WORD_W-1:0]    num_q;
	logic [gfsr_pkg::WORD_W-1:0]    rem_q;
	logic [gfsr_pkg::WORD_W:0]      shifted;
	logic [gfsr_pkg::WORD_W:0]      diff;

	// Bring down the next dividend bit and try a subtraction.
	always_comb begin
		shifted = {rem_q, num_q[gfsr_pkg::WORD_W-1]};
		diff    = shifted - {1'b0, divisor};
	end

	// Iteration count and completion flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= gfsr_pkg::DIV_CNT_W'(gfsr_pkg::WORD_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == gfsr_pkg::DIV_CNT_W'(1));
		end
	end

	// Partial remainder and the dividend bits still to come.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			num_q <= {num_q[gfsr_pkg::WORD_W-2:0], 1'b0};
			if (!diff[gfsr_pkg::WORD_W]) begin
				rem_q <= diff[gfsr_pkg::WORD_W-1:0];
			end else begin
				rem_q <= shifted[gfsr_pkg::WORD_W-1:0];
			end
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

/* src/gfsr_dp.sv */
// Datapath: request register, word table, pointer, remainder unit and response register.
`default_nettype none

module gfsr_dp (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire gfsr_pkg::req_t req,
	input  wire gfsr_pkg::cmd_t cmd,
	output gfsr_pkg::sts_t      sts,
	output gfsr_pkg::rsp_t      rsp
);

	localparam logic [gfsr_pkg::PTR_W-1:0] LAST_POS = gfsr_pkg::PTR_W'(gfsr_pkg::TABLE_WORDS - 1);
	localparam logic [gfsr_pkg::PTR_W:0]   TAP_ADD  = (gfsr_pkg::PTR_W + 1)'(gfsr_pkg::TAP_MOD);
	localparam logic [gfsr_pkg::PTR_W:0]   WRAP     = (gfsr_pkg::PTR_W + 1)'(gfsr_pkg::TABLE_WORDS);

	gfsr_pkg::req_t               req_q;
	gfsr_pkg::req_kind_t          kind;
	gfsr_pkg::rsp_t               rsp_q;
	logic [gfsr_pkg::PTR_W-1:0]   pos_q;
	logic [gfsr_pkg::PTR_W-1:0]   next_pos;
	logic [gfsr_pkg::PTR_W:0]     tap_sum;
	logic [gfsr_pkg::PTR_W-1:0]   tap_pos;
	logic                         idx_ok;
	logic                         range_err;
	logic [gfsr_pkg::WORD_W-1:0]  span;
	logic [gfsr_pkg::WORD_W-1:0]  word_q;
	logic [gfsr_pkg::WORD_W-1:0]  new_word;

	// Word table with one valid bit per entry; an unwritten entry reads as zero.
	logic [gfsr_pkg::WORD_W-1:0]  mem [gfsr_pkg::TABLE_WORDS];
	logic [gfsr_pkg::TABLE_WORDS-1:0] vld_q;
	logic                         wr_en;
	logic [gfsr_pkg::PTR_W-1:0]   wr_addr;
	logic [gfsr_pkg::WORD_W-1:0]  wr_data;
	logic [gfsr_pkg::WORD_W-1:0]  rd_a_q;
	logic [gfsr_pkg::WORD_W-1:0]  rd_b_q;
	logic                         rd_a_vld_q;
	logic                         rd_b_vld_q;

	logic                         div_done;
	logic [gfsr_pkg::WORD_W-1:0]  div_rem;

	// Hold the accepted item for the length of its work.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
	end

	// Decode of the held item.
	always_comb begin
		kind      = gfsr_pkg::req_kind_t'(req_q.req_type);
		idx_ok    = 32'(req_q.word_index) < 32'(gfsr_pkg::TABLE_WORDS);
		range_err = req_q.range_high < req_q.range_low;
		span      = {1'b0, req_q.range_high} - {1'b0, req_q.range_low} + 32'd1;
	end

	// Pointer advance and the tap position ahead of it.
	always_comb begin
		next_pos = (pos_q == LAST_POS) ? '0 : pos_q + 1'b1;
		tap_sum  = {1'b0, next_pos} + TAP_ADD;
		if (tap_sum >= WRAP) begin
			tap_sum = tap_sum - WRAP;
		end
		tap_pos = tap_sum[gfsr_pkg::PTR_W-1:0];
	end

	// Position pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (cmd.ptr_load && idx_ok) begin
			pos_q <= gfsr_pkg::PTR_W'(req_q.word_index);
		end else if (cmd.advance) begin
			pos_q <= next_pos;
		end
	end

	// Single write port, shared by seed loads and feedback write-back.
	always_comb begin
		new_word = (rd_a_vld_q ? rd_a_q : '0) ^ (rd_b_vld_q ? rd_b_q : '0);
		wr_en    = (cmd.mem_load && idx_ok) || cmd.commit;
		wr_addr  = cmd.commit ? pos_q : gfsr_pkg::PTR_W'(req_q.word_index);
		wr_data  = cmd.commit ? new_word : req_q.seed_value;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_a_q <= mem[next_pos];
		rd_b_q <= mem[tap_pos];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			rd_a_vld_q <= 1'b0;
			rd_b_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rd_a_vld_q <= vld_q[next_pos];
			rd_b_vld_q <= vld_q[tap_pos];
		end
	end

	// Latest drawn word.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			word_q <= new_word;
		end
	end

	// Reduction of the drawn word modulo the span.
	gfsr_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (new_word),
		.divisor   (span),
		.done      (div_done),
		.remainder (div_rem)
	);

	// Response register.
	always_ff @(posedge clk) begin
		if (cmd.rsp_load) begin
			unique case (kind)
				gfsr_pkg::KIND_LOAD_WORD, gfsr_pkg::KIND_LOAD_PTR: begin
					rsp_q.draw_value <= '0;
					rsp_q.status     <= 1'b0;
				end
				gfsr_pkg::KIND_DRAW_RAW: begin
					rsp_q.draw_value <= word_q;
					rsp_q.status     <= 1'b0;
				end
				gfsr_pkg::KIND_DRAW_RANGE: begin
					if (range_err) begin
						rsp_q.draw_value <= '0;
						rsp_q.status     <= 1'b1;
					end else begin
						rsp_q.draw_value <= div_rem + {1'b0, req_q.range_low};
						rsp_q.status     <= 1'b0;
					end
				end
				default: begin
					rsp_q.draw_value <= '0;
					rsp_q.status     <= 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		sts.kind      = kind;
		sts.range_err = range_err;
		sts.div_done  = div_done;
	end

	assign rsp = rsp_q;

endmodule

`default_nettype wire

/* src/gfsr_ctrl.sv */
// Controller state machine: sequences each item and owns both handshakes.
`default_nettype none

module gfsr_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	input  wire gfsr_pkg::sts_t sts,
	output gfsr_pkg::cmd_t      cmd
);

	gfsr_pkg::state_t state_q;
	gfsr_pkg::state_t state_d;
	logic             rsp_valid_q;
	logic             out_free;

	// The response register can take a new item once the old one is gone.
	assign out_free = !rsp_valid_q || rsp_ready;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gfsr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gfsr_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_d = gfsr_pkg::ST_EXEC;
				end
			end
			gfsr_pkg::ST_EXEC: begin
				unique case (sts.kind)
					gfsr_pkg::KIND_DRAW_RAW: begin
						state_d = gfsr_pkg::ST_XOR;
					end
					gfsr_pkg::KIND_DRAW_RANGE: begin
						state_d = sts.range_err ? gfsr_pkg::ST_FINISH : gfsr_pkg::ST_XOR;
					end
					default: begin
						state_d = gfsr_pkg::ST_FINISH;
					end
				endcase
			end
			gfsr_pkg::ST_XOR: begin
				state_d = (sts.kind == gfsr_pkg::KIND_DRAW_RANGE) ?
					gfsr_pkg::ST_DIV : gfsr_pkg::ST_FINISH;
			end
			gfsr_pkg::ST_DIV: begin
				if (sts.div_done) begin
					state_d = gfsr_pkg::ST_FINISH;
				end
			end
			gfsr_pkg::ST_FINISH: begin
				if (out_free) begin
					state_d = gfsr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = gfsr_pkg::ST_IDLE;
			end
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			gfsr_pkg::ST_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
			end
			gfsr_pkg::ST_EXEC: begin
				unique case (sts.kind)
					gfsr_pkg::KIND_LOAD_WORD:  cmd.mem_load = 1'b1;
					gfsr_pkg::KIND_LOAD_PTR:   cmd.ptr_load = 1'b1;
					gfsr_pkg::KIND_DRAW_RAW:   cmd.advance  = 1'b1;
					gfsr_pkg::KIND_DRAW_RANGE: cmd.advance  = !sts.range_err;
					default:                   cmd.advance  = 1'b0;
				endcase
			end
			gfsr_pkg::ST_XOR: begin
				cmd.commit    = 1'b1;
				cmd.div_start = (sts.kind == gfsr_pkg::KIND_DRAW_RANGE);
			end
			gfsr_pkg::ST_DIV: begin
				cmd = '0;
			end
			gfsr_pkg::ST_FINISH: begin
				cmd.rsp_load = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// Response valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

`default_nettype wire

/* src/gfsr_random_word_generator.sv */
// After acceptance, a load passes through the execute and finish states; a raw draw adds
// the XOR write-back, and a ranged draw with a valid range also the one-bit-per-cycle remainder unit.
// One item is in work at a time; the next item can be taken in the cycle after the
// response register is loaded.
// Reset clears the pointer and all table valid bits at once, so the table reads as zero;
// no clearing pass is needed and an item may be offered in the first cycle after reset.
`default_nettype none

module gfsr_random_word_generator (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire gfsr_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output gfsr_pkg::rsp_t      rsp
);

	gfsr_pkg::cmd_t cmd;
	gfsr_pkg::sts_t sts;

	// Sequencing of each item.
	gfsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Table, pointer and arithmetic.
	gfsr_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire
